FILE: sv/cia_pkg.sv
// Package for the timer / time-of-day / serial interface adapter.
// Holds function codes, register indexes, field widths and BCD helpers.
`default_nettype none
package cia_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned TodDivBitsDefault = 24;
    localparam logic [23:0] TodDivReset = 24'd100000;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [3:0] REG_PRA = 4'd0;
    localparam logic [3:0] REG_PRB = 4'd1;
    localparam logic [3:0] REG_DDRA = 4'd2;
    localparam logic [3:0] REG_DDRB = 4'd3;
    localparam logic [3:0] REG_TALO = 4'd4;
    localparam logic [3:0] REG_TAHI = 4'd5;
    localparam logic [3:0] REG_TBLO = 4'd6;
    localparam logic [3:0] REG_TBHI = 4'd7;
    localparam logic [3:0] REG_TOD10 = 4'd8;
    localparam logic [3:0] REG_TODS = 4'd9;
    localparam logic [3:0] REG_TODM = 4'd10;
    localparam logic [3:0] REG_TODH = 4'd11;
    localparam logic [3:0] REG_SDR = 4'd12;
    localparam logic [3:0] REG_ICR = 4'd13;
    localparam logic [3:0] REG_CRA = 4'd14;
    localparam logic [3:0] REG_CRB = 4'd15;

    localparam logic [0:0] CFG_DIV50 = 1'b0;
    localparam logic [0:0] CFG_DIV60 = 1'b1;

    typedef struct packed {
        logic [7:0] tenth;
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hr;
    } t_tod;

    localparam t_tod TodReset = '{tenth: 8'h00, sec: 8'h00, min: 8'h00, hr: 8'h12};

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] pa_pull_dn;
        logic [7:0] pb_pull_dn;
        logic       cnt_edge;
        logic       sp_level;
        logic       flag_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       pc_line;
        logic       sp_out;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
    } t_out_item;

    function automatic logic [7:0] bcd_val(input logic [7:0] v);
        bcd_val = 8'({4'd0, v[7:4]} * 8'd10 + {4'd0, v[3:0]});
    endfunction

    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] rem;
        tens = 4'((16'(v) * 16'd205) >> 11);
        rem = 7'(v - 7'(7'(tens) * 7'd10));
        to_bcd = {tens, rem[3:0]};
    endfunction

    function automatic logic [7:0] sane_bcd(input logic [7:0] v);
        logic [7:0] d;
        d = bcd_val(v);
        if (v[3:0] > 4'd9 || d > 8'd59) begin
            d = 8'd0;
        end
        sane_bcd = to_bcd(d[6:0]);
    endfunction

    function automatic logic [7:0] port_level(input logic [7:0] data, input logic [7:0] dir);
        port_level = (data & dir) | ~dir;
    endfunction
endpackage
`default_nettype wire

FILE: sv/cia_stream_if.sv
// Valid/ready channel interface for one beat of a payload type.
// The payload type is given as a parameter; the interface does not import cia_pkg.
`default_nettype none
interface cia_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/interface_adapter_timers_tod_serial.sv
// Top level of the timer / time-of-day / serial interface adapter.
// Depends on cia_pkg, cia_stream_if and cia_tod_adv.
// Output: the result of each accepted beat is held in a registered output beat.
// Throughput: one beat per cycle while the output is not stalled; the state update is a single registered pass.
// Reset: synchronous active-low reset restores every control register at once.
// No clearing pass follows reset.
`default_nettype none
module interface_adapter_timers_tod_serial
    import cia_pkg::*;
#(
    parameter int unsigned TOD_DIV_BITS = TodDivBitsDefault
) (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_cfg_we,
    input  var logic [CfgIdxW-1:0]  i_cfg_idx,
    input  var logic [CfgDataW-1:0] i_cfg_data,
    cia_stream_if.sink              i_in,
    cia_stream_if.source            o_out
);
    typedef struct packed {
        logic [1:0] start_dly;
        logic [1:0] load_dly;
        logic [1:0] os_dly;
        logic ld_hold, skip, os_eff, os_pend, os_wr_pend, os_wr_val, level, pulse;
    } t_pipe;

    logic [7:0]  r_rf [16];
    logic [15:0] r_cnt [2];
    logic [15:0] r_rld [2];
    t_pipe       r_p [2];
    t_tod        r_now, r_alm, r_hold;
    logic        r_latched;
    logic [TOD_DIV_BITS-1:0] r_div;
    logic [23:0] r_d50, r_d60;
    logic [4:0]  r_flags, r_mask;
    logic        r_ff, r_pend, r_line;
    logic [7:0]  r_shift, r_pdat;
    logic [3:0]  r_obits, r_icnt;
    logic        r_spend, r_tog, r_sp;
    logic        r_flag, r_pc, r_req;
    logic        r_ovalid;
    t_out_item   r_obeat;

    logic [7:0]  n_rf [16];
    logic [15:0] n_cnt [2];
    logic [15:0] n_rld [2];
    t_pipe       n_p [2];
    t_tod        n_now, n_alm, n_hold;
    logic        n_latched;
    logic [TOD_DIV_BITS-1:0] n_div;
    logic [4:0]  n_flags, n_mask;
    logic        n_ff, n_pend, n_line;
    logic [7:0]  n_shift, n_pdat;
    logic [3:0]  n_obits, n_icnt;
    logic        n_spend, n_tog, n_sp;
    logic        n_flag, n_pc, n_req;
    t_out_item   n_obeat;

    t_tod        tod_inc;
    t_in_item    it;
    logic        acc;
    logic [23:0] divsel;

    cia_tod_adv u_tod_adv (.i_now(r_now), .o_next(tod_inc));

    assign it = i_in.payload;
    assign i_in.ready = ~r_ovalid | o_out.ready;
    assign acc = i_in.valid & i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_obeat;

    always_comb begin
        logic uf [2];
        logic [7:0] ctl, rd, v, h7, pbv;
        logic loaded, os_uf, cnt_en;
        logic [6:0] hv;
        t_tod tsel;
        logic tsel_alm;
        n_rf = r_rf; n_cnt = r_cnt; n_rld = r_rld; n_p = r_p;
        n_now = r_now; n_alm = r_alm; n_hold = r_hold; n_latched = r_latched;
        n_div = r_div; n_flags = r_flags; n_mask = r_mask; n_ff = r_ff;
        n_pend = r_pend; n_line = r_line; n_shift = r_shift; n_pdat = r_pdat;
        n_obits = r_obits; n_icnt = r_icnt; n_spend = r_spend; n_tog = r_tog;
        n_sp = r_sp; n_flag = r_flag; n_pc = r_pc; n_req = r_req;
        uf[0] = 1'b0; uf[1] = 1'b0;
        rd = 8'd0; v = 8'd0; h7 = 8'd0; hv = 7'd0; ctl = 8'd0;
        loaded = 1'b0; os_uf = 1'b0; cnt_en = 1'b0; pbv = 8'd0;
        tsel = r_now; tsel_alm = 1'b0;
        divsel = r_rf[REG_CRA][7] ? r_d50 : r_d60;

        if (r_flag && !it.flag_level) begin
            n_flags = n_flags | 5'h10;
            if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
        end
        n_flag = it.flag_level;

        case (it.func)
            FUNC_TICK: begin
                for (int i = 0; i < 2; i++) begin
                    if (n_p[i].pulse) n_p[i].level = 1'b1;
                    n_p[i].pulse = 1'b0;
                end
                for (int i = 0; i < 2; i++) begin
                    ctl = n_rf[14+i];
                    loaded = 1'b0;
                    if (n_p[i].load_dly != 2'd0) begin
                        n_p[i].load_dly = 2'(n_p[i].load_dly - 2'd1);
                        if (n_p[i].load_dly == 2'd0) begin
                            n_cnt[i] = (n_rld[i] == 16'd0) ? 16'hffff : n_rld[i];
                            n_p[i].ld_hold = 1'b1;
                            loaded = 1'b1;
                        end
                    end else if (n_p[i].ld_hold) begin
                        n_p[i].ld_hold = 1'b0;
                        loaded = 1'b1;
                    end
                    os_uf = n_p[i].os_eff;
                    if (n_p[i].os_dly != 2'd0) begin
                        n_p[i].os_dly = 2'(n_p[i].os_dly - 2'd1);
                        if (n_p[i].os_dly == 2'd0) n_p[i].os_eff = n_p[i].os_pend;
                    end
                    if (!ctl[0]) begin
                        n_p[i].start_dly = 2'd0;
                    end else if (n_p[i].start_dly != 2'd0) begin
                        n_p[i].start_dly = 2'(n_p[i].start_dly - 2'd1);
                    end else begin
                        if (i == 0) cnt_en = ctl[5] ? it.cnt_edge : 1'b1;
                        else begin
                            case (ctl[6:5])
                                2'd0: cnt_en = 1'b1;
                                2'd1: cnt_en = it.cnt_edge;
                                2'd2: cnt_en = uf[0];
                                default: cnt_en = uf[0] & it.cnt_edge;
                            endcase
                        end
                        if (cnt_en && !loaded) begin
                            if (n_p[i].skip) begin
                                n_p[i].skip = 1'b0;
                            end else if (n_cnt[i] <= 16'd1) begin
                                uf[i] = 1'b1;
                                n_flags = n_flags | 5'(1 << i);
                                if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
                                if (ctl[1]) begin
                                    if (ctl[2]) n_p[i].level = ~n_p[i].level;
                                    else begin
                                        n_p[i].pulse = 1'b1;
                                        n_p[i].level = 1'b0;
                                    end
                                end
                                n_cnt[i] = (n_rld[i] == 16'd0) ? 16'hffff : n_rld[i];
                                n_p[i].skip = 1'b1;
                                if (os_uf) n_rf[14+i] = n_rf[14+i] & 8'hfe;
                            end else begin
                                n_cnt[i] = 16'(n_cnt[i] - 16'd1);
                            end
                        end
                    end
                    if (n_p[i].os_wr_pend) begin
                        if (!(n_p[i].os_wr_val == n_p[i].os_eff && n_p[i].os_dly == 2'd0))
                            n_p[i].os_dly = n_p[i].os_wr_val ? 2'd1 : 2'd2;
                        n_p[i].os_pend = n_p[i].os_wr_val;
                        n_p[i].os_wr_pend = 1'b0;
                    end
                end
                if (n_rf[REG_CRA][6]) begin
                    if (n_obits != 4'd0 && uf[0]) begin
                        n_tog = ~n_tog;
                        if (!n_tog) begin
                            n_sp = n_shift[7];
                            n_shift = {n_shift[6:0], 1'b0};
                            n_obits = 4'(n_obits - 4'd1);
                            if (n_obits == 4'd0) begin
                                n_flags = n_flags | 5'h08;
                                if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
                                if (n_spend) begin
                                    n_shift = n_pdat;
                                    n_obits = 4'd8;
                                    n_spend = 1'b0;
                                end
                            end
                        end
                    end
                end else if (it.cnt_edge) begin
                    n_shift = {n_shift[6:0], it.sp_level};
                    n_icnt = 4'(n_icnt + 4'd1);
                    if (n_icnt >= 4'd8) begin
                        n_rf[REG_SDR] = n_shift;
                        n_icnt = 4'd0;
                        n_flags = n_flags | 5'h08;
                        if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
                    end
                end
                divsel = n_rf[REG_CRA][7] ? r_d50 : r_d60;
                if (divsel != 24'd0) begin
                    n_div = r_div + TOD_DIV_BITS'(1);
                    if (33'(n_div) >= 33'(divsel)) begin
                        n_div = TOD_DIV_BITS'(33'(n_div) - 33'(divsel));
                        n_now = tod_inc;
                        if (tod_inc == r_alm) begin
                            n_flags = n_flags | 5'h04;
                        end
                    end
                end
                if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
                n_line = r_pend;
                n_pend = n_ff;
                n_pc = ~r_req;
                n_req = 1'b0;
            end
            FUNC_READ: begin
                case (it.reg_addr)
                    REG_PRA: rd = port_level(r_rf[REG_PRA], r_rf[REG_DDRA])
                                  & ~it.pa_pull_dn;
                    REG_PRB: begin
                        n_req = 1'b1;
                        pbv = port_level(r_rf[REG_PRB], r_rf[REG_DDRB]) & ~it.pb_pull_dn;
                        for (int i = 0; i < 2; i++) begin
                            if (r_rf[14+i][1])
                                pbv[6+i] = ~(r_p[i].pulse | ~r_p[i].level);
                        end
                        rd = pbv;
                    end
                    REG_TALO: rd = r_cnt[0][7:0];
                    REG_TAHI: rd = r_cnt[0][15:8];
                    REG_TBLO: rd = r_cnt[1][7:0];
                    REG_TBHI: rd = r_cnt[1][15:8];
                    REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
                        if (it.reg_addr == REG_TODH && !r_latched) begin
                            n_hold = r_now;
                            n_latched = 1'b1;
                        end
                        tsel = n_latched ? n_hold : r_now;
                        case (it.reg_addr)
                            REG_TOD10: begin
                                rd = tsel.tenth;
                                n_latched = 1'b0;
                            end
                            REG_TODS: rd = tsel.sec;
                            REG_TODM: rd = tsel.min;
                            default: rd = tsel.hr;
                        endcase
                    end
                    REG_ICR: begin
                        rd = {(r_ff | ((n_flags & r_mask) != 5'd0)), 2'b00, n_flags};
                        n_flags = 5'd0;
                        n_ff = 1'b0;
                    end
                    default: rd = r_rf[it.reg_addr];
                endcase
            end
            FUNC_WRITE: begin
                v = it.write_data;
                case (it.reg_addr)
                    REG_ICR: begin
                        if (v[7]) n_mask = r_mask | v[4:0];
                        else n_mask = r_mask & ~v[4:0];
                        n_rf[REG_ICR] = {3'd0, n_mask};
                        if ((n_flags & n_mask) != 5'd0) n_ff = 1'b1;
                    end
                    REG_CRA, REG_CRB: begin
                        for (int i = 0; i < 2; i++) begin
                            if (it.reg_addr[0] == 1'(i)) begin
                                n_rf[14+i] = v & 8'hef;
                                if (v[4]) n_p[i].load_dly = 2'd2;
                                if (!r_rf[14+i][0] && v[0]) begin
                                    n_p[i].start_dly = 2'd2;
                                    n_p[i].skip = 1'b0;
                                end
                                if (!v[0]) n_p[i].start_dly = 2'd0;
                                n_p[i].os_wr_val = v[3];
                                n_p[i].os_wr_pend = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_rf[it.reg_addr] = v;
                        tsel_alm = r_rf[REG_CRB][7];
                        tsel = tsel_alm ? r_alm : r_now;
                        case (it.reg_addr)
                            REG_PRB: n_req = 1'b1;
                            REG_TALO: n_rld[0] = {r_rld[0][15:8], v};
                            REG_TBLO: n_rld[1] = {r_rld[1][15:8], v};
                            REG_TAHI, REG_TBHI: begin
                                for (int i = 0; i < 2; i++) begin
                                    if (it.reg_addr[1] == 1'(i)) begin
                                        n_rld[i] = {v, r_rld[i][7:0]};
                                        if (!r_rf[14+i][0])
                                            n_cnt[i] = (n_rld[i] == 16'd0) ? 16'hffff : n_rld[i];
                                    end
                                end
                            end
                            REG_TOD10: begin
                                tsel.tenth = (v <= 8'd9) ? v : 8'd0;
                                if (!tsel_alm) begin
                                    n_div = '0;
                                    n_latched = 1'b0;
                                end
                            end
                            REG_TODS: tsel.sec = sane_bcd(v);
                            REG_TODM: tsel.min = sane_bcd(v);
                            REG_TODH: begin
                                h7 = {3'd0, v[4:0]};
                                hv = 7'(bcd_val(h7));
                                if (v[3:0] > 4'd9 || hv < 7'd1 || hv > 7'd12) hv = 7'd12;
                                tsel.hr = {v[7], 7'd0} | to_bcd(hv);
                            end
                            REG_SDR: begin
                                if (r_rf[REG_CRA][6]) begin
                                    if (r_obits == 4'd0) begin
                                        n_shift = v;
                                        n_obits = 4'd8;
                                        n_tog = 1'b0;
                                    end else begin
                                        n_pdat = v;
                                        n_spend = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                        if (it.reg_addr == REG_TOD10 || it.reg_addr == REG_TODS
                            || it.reg_addr == REG_TODM || it.reg_addr == REG_TODH) begin
                            if (tsel_alm) n_alm = tsel;
                            else n_now = tsel;
                        end
                    end
                endcase
            end
            default: ;
        endcase

        pbv = port_level(n_rf[REG_PRB], n_rf[REG_DDRB]);
        for (int i = 0; i < 2; i++) begin
            if (n_rf[14+i][1]) pbv[6+i] = ~(n_p[i].pulse | ~n_p[i].level);
        end
        n_obeat.read_data = rd;
        n_obeat.irq_line = n_line;
        n_obeat.pc_line = n_pc;
        n_obeat.sp_out = n_sp;
        n_obeat.port_a_out = port_level(n_rf[REG_PRA], n_rf[REG_DDRA]);
        n_obeat.port_b_out = pbv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_rf[i] <= 8'd0;
            for (int i = 0; i < 2; i++) begin
                r_cnt[i] <= 16'd0;
                r_rld[i] <= 16'd0;
                r_p[i] <= '0;
                r_p[i].level <= 1'b1;
            end
            r_now <= TodReset; r_alm <= TodReset; r_hold <= '0; r_latched <= 1'b0;
            r_div <= '0; r_d50 <= TodDivReset; r_d60 <= TodDivReset;
            r_flags <= '0; r_mask <= '0; r_ff <= 1'b0; r_pend <= 1'b0; r_line <= 1'b0;
            r_shift <= '0; r_pdat <= '0; r_obits <= '0; r_icnt <= '0;
            r_spend <= 1'b0; r_tog <= 1'b0; r_sp <= 1'b0;
            r_flag <= 1'b1; r_pc <= 1'b1; r_req <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIV50) r_d50 <= i_cfg_data;
                else if (i_cfg_idx == CFG_DIV60) r_d60 <= i_cfg_data;
            end
            if (acc) begin
                r_rf <= n_rf; r_cnt <= n_cnt; r_rld <= n_rld; r_p <= n_p;
                r_now <= n_now; r_alm <= n_alm; r_hold <= n_hold; r_latched <= n_latched;
                r_div <= n_div; r_flags <= n_flags; r_mask <= n_mask; r_ff <= n_ff;
                r_pend <= n_pend; r_line <= n_line; r_shift <= n_shift; r_pdat <= n_pdat;
                r_obits <= n_obits; r_icnt <= n_icnt; r_spend <= n_spend; r_tog <= n_tog;
                r_sp <= n_sp; r_flag <= n_flag; r_pc <= n_pc; r_req <= n_req;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_obeat <= n_obeat;
    end

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> $stable(r_obeat))
        else $error("result beat changed while stalled");
    a_irq_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.payload.func == FUNC_TICK |=> r_line == $past(r_pend))
        else $error("interrupt line skipped its delay stage");
    a_obits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_obits <= 4'd8 && r_icnt <= 4'd7)
        else $error("serial counters out of range");
endmodule
`default_nettype wire

FILE: sv/cia_tod_adv.sv
// Time-of-day single tenth increment with BCD roll-over and AM/PM flip.
// Depends on cia_pkg.
`default_nettype none
module cia_tod_adv
    import cia_pkg::*;
(
    input  var t_tod i_now,
    output var t_tod o_next
);
    logic [6:0] v_sec;
    logic [6:0] v_min;
    logic [6:0] v_hr;
    logic       pm;

    always_comb begin
        o_next = i_now;
        v_sec = 7'(bcd_val(i_now.sec) + 8'd1);
        v_min = 7'(bcd_val(i_now.min) + 8'd1);
        v_hr = 7'(bcd_val({3'd0, i_now.hr[4:0]}) + 8'd1);
        pm = i_now.hr[7];
        if (i_now.tenth + 8'd1 < 8'd10) begin
            o_next.tenth = 8'(i_now.tenth + 8'd1);
        end else begin
            o_next.tenth = 8'd0;
            if (v_sec < 7'd60) begin
                o_next.sec = to_bcd(v_sec);
            end else begin
                o_next.sec = 8'd0;
                if (v_min < 7'd60) begin
                    o_next.min = to_bcd(v_min);
                end else begin
                    o_next.min = 8'd0;
                    if (v_hr == 7'd12) begin
                        pm = ~pm;
                    end else if (v_hr > 7'd12) begin
                        v_hr = 7'd1;
                    end
                    o_next.hr = {pm, 7'd0} | to_bcd(v_hr);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for interface_adapter_timers_tod_serial.
// A cycle-level predictor of the registers, timers, time of day, serial shifter and interrupts
// is run on every accepted input beat; depends on cia_pkg and cia_stream_if.
`timescale 1ns / 100ps
module tb_top;
    import cia_pkg::*;

    typedef struct {
        bit [7:0] start_dly, load_dly, os_dly;
        bit       ld_hold, skip, os_eff, os_pend, os_wr_pend, os_wr_val, level, pulse;
    } tmr_pipe_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    cia_stream_if #(.T(t_in_item))  in_if ();
    cia_stream_if #(.T(t_out_item)) out_if ();

    interface_adapter_timers_tod_serial i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    // Predicted adapter state.
    bit [23:0] div_50hz, div_60hz;
    bit [7:0]  regs[16];
    bit [15:0] tmr_cnt[2], tmr_latch[2];
    tmr_pipe_t tmr[2];
    t_tod      tod_live, tod_alm, tod_snap;
    bit        tod_snapped;
    bit [23:0] tod_acc;
    bit [7:0]  icr_flags, icr_mask;
    bit        icr_ff, icr_pend, icr_pin;
    bit [7:0]  sdr_shift, sdr_next, sdr_bits, sdr_in_cnt;
    bit        sdr_pending, sdr_toggle, sdr_pin;
    bit        flag_q, pc_q, pc_req;

    t_out_item expected_beats[$];
    int        n_errors, n_checked, n_sent, n_ticks, n_reads, n_writes;
    bit        flag_drv;
    bit        no_idle;
    int        out_stall;

    function automatic bit [7:0] bcd2bin(bit [7:0] v);
        return 8'(v[7:4] * 10 + v[3:0]);
    endfunction

    function automatic bit [7:0] bin2bcd(bit [7:0] v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic bit [7:0] clean_bcd(bit [7:0] v);
        bit [7:0] d;
        d = bcd2bin(v);
        if (v[3:0] > 9 || d > 59) d = 0;
        return bin2bcd(d);
    endfunction

    function automatic bit [7:0] pins(bit [7:0] data, bit [7:0] dir);
        return (data & dir) | ~dir;
    endfunction

    function void raise_flag(bit [7:0] src);
        icr_flags = (icr_flags | src) & 8'h1f;
        if ((icr_flags & icr_mask & 8'h1f) != 0) icr_ff = 1;
    endfunction

    function bit [15:0] reload_val(int i);
        return tmr_latch[i] == 0 ? 16'hffff : tmr_latch[i];
    endfunction

    function bit [7:0] mix_pb(bit [7:0] v);
        bit [7:0] m;
        for (int i = 0; i < 2; i++) begin
            m = 8'h40 << i;
            if (regs[14+i][1]) begin
                if (tmr[i].pulse || !tmr[i].level) v = v & ~m;
                else v = v | m;
            end
        end
        return v;
    endfunction

    function void oneshot_set(int i, bit os);
        if (os == tmr[i].os_eff && tmr[i].os_dly == 0) begin
            tmr[i].os_pend = os;
            return;
        end
        tmr[i].os_pend = os;
        tmr[i].os_dly = os ? 1 : 2;
    endfunction

    function bit timer_step(int i, bit cnt, bit a_uf);
        bit [7:0] ctl;
        bit loaded, os_uf, cnt_en, uf;
        ctl = regs[14+i];
        loaded = 0;
        uf = 0;
        cnt_en = 0;
        if (tmr[i].load_dly > 0) begin
            tmr[i].load_dly--;
            if (tmr[i].load_dly == 0) begin
                tmr_cnt[i] = reload_val(i);
                tmr[i].ld_hold = 1;
                loaded = 1;
            end
        end else if (tmr[i].ld_hold) begin
            tmr[i].ld_hold = 0;
            loaded = 1;
        end
        os_uf = tmr[i].os_eff;
        if (tmr[i].os_dly != 0) begin
            tmr[i].os_dly--;
            if (tmr[i].os_dly == 0) tmr[i].os_eff = tmr[i].os_pend;
        end
        if (!ctl[0]) begin
            tmr[i].start_dly = 0;
        end else if (tmr[i].start_dly > 0) begin
            tmr[i].start_dly--;
        end else begin
            if (i == 0) cnt_en = ctl[5] ? cnt : 1'b1;
            else begin
                case (ctl[6:5])
                    2'd0: cnt_en = 1;
                    2'd1: cnt_en = cnt;
                    2'd2: cnt_en = a_uf;
                    default: cnt_en = a_uf && cnt;
                endcase
            end
            if (cnt_en && !loaded) begin
                if (tmr[i].skip) begin
                    tmr[i].skip = 0;
                end else if (tmr_cnt[i] <= 1) begin
                    uf = 1;
                    raise_flag(8'(1 << i));
                    if (ctl[1]) begin
                        if (ctl[2]) tmr[i].level = !tmr[i].level;
                        else begin
                            tmr[i].pulse = 1;
                            tmr[i].level = 0;
                        end
                    end
                    tmr_cnt[i] = reload_val(i);
                    tmr[i].skip = 1;
                    if (os_uf) regs[14+i] = regs[14+i] & 8'hfe;
                end else begin
                    tmr_cnt[i]--;
                end
            end
        end
        if (tmr[i].os_wr_pend) begin
            oneshot_set(i, tmr[i].os_wr_val);
            tmr[i].os_wr_pend = 0;
        end
        return uf;
    endfunction

    function void serial_step(bit a_uf, bit cnt, bit sp);
        if (regs[14][6]) begin
            if (sdr_bits != 0 && a_uf) begin
                sdr_toggle = !sdr_toggle;
                if (!sdr_toggle) begin
                    sdr_pin = sdr_shift[7];
                    sdr_shift = sdr_shift << 1;
                    sdr_bits--;
                    if (sdr_bits == 0) begin
                        raise_flag(8'h08);
                        if (sdr_pending) begin
                            sdr_shift = sdr_next;
                            sdr_bits = 8;
                            sdr_pending = 0;
                        end
                    end
                end
            end
        end else if (cnt) begin
            sdr_shift = {sdr_shift[6:0], sp};
            sdr_in_cnt++;
            if (sdr_in_cnt >= 8) begin
                regs[12] = sdr_shift;
                sdr_in_cnt = 0;
                raise_flag(8'h08);
            end
        end
    endfunction

    function void tod_advance();
        bit [7:0] v, pm;
        tod_live.tenth = tod_live.tenth + 1;
        if (tod_live.tenth < 10) return;
        tod_live.tenth = 0;
        v = bcd2bin(tod_live.sec) + 1;
        if (v < 60) begin
            tod_live.sec = bin2bcd(v);
            return;
        end
        tod_live.sec = 0;
        v = bcd2bin(tod_live.min) + 1;
        if (v < 60) begin
            tod_live.min = bin2bcd(v);
            return;
        end
        tod_live.min = 0;
        pm = tod_live.hr & 8'h80;
        v = bcd2bin(tod_live.hr & 8'h1f) + 1;
        if (v == 12) pm ^= 8'h80;
        else if (v > 12) v = 1;
        tod_live.hr = pm | bin2bcd(v);
    endfunction

    function void tod_step();
        bit [23:0] dv;
        dv = regs[14][7] ? div_50hz : div_60hz;
        if (dv == 0) return;
        tod_acc = tod_acc + 1;
        if (tod_acc >= dv) begin
            tod_acc = tod_acc - dv;
            tod_advance();
            if (tod_live == tod_alm) raise_flag(8'h04);
        end
    endfunction

    function void clock_step(bit cnt, bit sp);
        bit a_uf;
        for (int i = 0; i < 2; i++) begin
            if (tmr[i].pulse) tmr[i].level = 1;
            tmr[i].pulse = 0;
        end
        a_uf = timer_step(0, cnt, 0);
        void'(timer_step(1, cnt, a_uf));
        serial_step(a_uf, cnt, sp);
        tod_step();
        if ((icr_flags & icr_mask & 8'h1f) != 0) icr_ff = 1;
        icr_pin = icr_pend;
        icr_pend = icr_ff;
        pc_q = !pc_req;
        pc_req = 0;
    endfunction

    function bit [7:0] bus_read(bit [3:0] r, bit [7:0] pa, bit [7:0] pb);
        t_tod t;
        bit [7:0] v;
        case (r)
            REG_PRA: return pins(regs[0], regs[2]) & ~pa;
            REG_PRB: begin
                pc_req = 1;
                return mix_pb(pins(regs[1], regs[3]) & ~pb);
            end
            REG_TALO, REG_TBLO: return tmr_cnt[r[1]][7:0];
            REG_TAHI, REG_TBHI: return tmr_cnt[r[1]][15:8];
            REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
                if (r == REG_TODH && !tod_snapped) begin
                    tod_snap = tod_live;
                    tod_snapped = 1;
                end
                t = tod_snapped ? tod_snap : tod_live;
                if (r == REG_TOD10) begin
                    tod_snapped = 0;
                    return t.tenth;
                end
                return r == REG_TODS ? t.sec : (r == REG_TODM ? t.min : t.hr);
            end
            REG_ICR: begin
                v = icr_flags & 8'h1f;
                if (icr_ff || (v & icr_mask) != 0) v |= 8'h80;
                icr_flags = 0;
                icr_ff = 0;
                return v;
            end
            default: return regs[r];
        endcase
    endfunction

    function void bus_write(bit [3:0] r, bit [7:0] v);
        bit was;
        bit [7:0] h;
        t_tod t;
        if (r == REG_ICR) begin
            if (v[7]) icr_mask = icr_mask | (v & 8'h1f);
            else icr_mask = icr_mask & ~(v & 8'h1f);
            regs[13] = icr_mask;
            if ((icr_flags & icr_mask & 8'h1f) != 0) icr_ff = 1;
            return;
        end
        if (r == REG_CRA || r == REG_CRB) begin
            was = regs[r][0];
            regs[r] = v & 8'hef;
            if (v[4]) tmr[r[0]].load_dly = 2;
            if (!was && v[0]) begin
                tmr[r[0]].start_dly = 2;
                tmr[r[0]].skip = 0;
            end
            if (!v[0]) tmr[r[0]].start_dly = 0;
            tmr[r[0]].os_wr_val = v[3];
            tmr[r[0]].os_wr_pend = 1;
            return;
        end
        regs[r] = v;
        case (r)
            REG_PRB: pc_req = 1;
            REG_TALO, REG_TBLO: tmr_latch[r[1]][7:0] = v;
            REG_TAHI, REG_TBHI: begin
                tmr_latch[r[1]][15:8] = v;
                if (!regs[14+r[1]][0]) tmr_cnt[r[1]] = reload_val(r[1]);
            end
            REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
                t = regs[15][7] ? tod_alm : tod_live;
                if (r == REG_TOD10) begin
                    t.tenth = v <= 9 ? v : 8'h00;
                    if (!regs[15][7]) begin
                        tod_acc = 0;
                        tod_snapped = 0;
                    end
                end else if (r == REG_TODS) t.sec = clean_bcd(v);
                else if (r == REG_TODM) t.min = clean_bcd(v);
                else begin
                    h = bcd2bin(v & 8'h1f);
                    if (v[3:0] > 9 || h < 1 || h > 12) h = 12;
                    t.hr = (v & 8'h80) | bin2bcd(h);
                end
                if (regs[15][7]) tod_alm = t;
                else tod_live = t;
            end
            REG_SDR: begin
                if (regs[14][6]) begin
                    if (sdr_bits == 0) begin
                        sdr_shift = v;
                        sdr_bits = 8;
                        sdr_toggle = 0;
                    end else begin
                        sdr_next = v;
                        sdr_pending = 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void adapter_reset();
        div_50hz = TodDivReset;
        div_60hz = TodDivReset;
        for (int i = 0; i < 16; i++) regs[i] = 0;
        for (int i = 0; i < 2; i++) begin
            tmr_cnt[i] = 0;
            tmr_latch[i] = 0;
            tmr[i] = '{default: 0};
            tmr[i].level = 1;
        end
        tod_live = TodReset;
        tod_alm = TodReset;
        tod_snap = '0;
        tod_snapped = 0;
        tod_acc = 0;
        icr_flags = 0;
        icr_mask = 0;
        {icr_ff, icr_pend, icr_pin} = 0;
        {sdr_shift, sdr_next, sdr_bits, sdr_in_cnt} = 0;
        {sdr_pending, sdr_toggle, sdr_pin} = 0;
        flag_q = 1;
        pc_q = 1;
        pc_req = 0;
    endfunction

    function t_out_item adapter_step(t_in_item it);
        t_out_item o;
        bit [7:0] rd;
        rd = 0;
        if (flag_q && !it.flag_level) raise_flag(8'h10);
        flag_q = it.flag_level;
        if (it.func == FUNC_TICK) clock_step(it.cnt_edge, it.sp_level);
        else if (it.func == FUNC_READ) rd = bus_read(it.reg_addr, it.pa_pull_dn,
                                                      it.pb_pull_dn);
        else if (it.func == FUNC_WRITE) bus_write(it.reg_addr, it.write_data);
        o.read_data = rd;
        o.irq_line = icr_pin;
        o.pc_line = pc_q;
        o.sp_out = sdr_pin;
        o.port_a_out = pins(regs[0], regs[2]);
        o.port_b_out = mix_pb(pins(regs[1], regs[3]));
        return o;
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function t_in_item make_beat(bit [1:0] f, bit [3:0] a, bit [7:0] d);
        t_in_item it;
        if ($urandom_range(0, 9) == 0) flag_drv = !flag_drv;
        it.func = f;
        it.reg_addr = a;
        it.write_data = d;
        it.pa_pull_dn = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00;
        it.pb_pull_dn = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00;
        it.cnt_edge = $urandom_range(0, 1);
        it.sp_level = $urandom_range(0, 1);
        it.flag_level = flag_drv;
        return it;
    endfunction

    task automatic send_beat(t_in_item it);
        int g;
        g = pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.payload <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_beats.push_back(adapter_step(it));
        n_sent++;
        case (it.func)
            FUNC_TICK: n_ticks++;
            FUNC_READ: n_reads++;
            FUNC_WRITE: n_writes++;
            default: ;
        endcase
    endtask

    task automatic tick_n(int n);
        repeat (n) send_beat(make_beat(FUNC_TICK, 4'($urandom), 8'($urandom)));
    endtask

    task automatic wr(bit [3:0] a, bit [7:0] d);
        send_beat(make_beat(FUNC_WRITE, a, d));
    endtask

    task automatic rd(bit [3:0] a);
        send_beat(make_beat(FUNC_READ, a, 8'($urandom)));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_beats.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_beats.size() != 0) begin
            $display("%0t: results stopped arriving, %0d outstanding", $realtime,
                     expected_beats.size());
            $display("TEST FAILED");
            $finish;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_divider(bit [CfgIdxW-1:0] idx, bit [23:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_DIV50) div_50hz = value;
        else div_60hz = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        t_in_item it;
        wr(REG_DDRA, 8'hff);
        wr(REG_PRA, 8'h5a);
        send_beat('{FUNC_READ, REG_PRA, 8'h00, 8'h0f, 8'hff, 1'b1, 1'b1, 1'b1});
        wr(REG_DDRB, 8'hf0);
        send_beat('{FUNC_READ, REG_PRB, 8'hff, 8'hff, 8'h00, 1'b0, 1'b0, 1'b1});
        wr(REG_TALO, 8'h00);
        wr(REG_TAHI, 8'h00);
        wr(REG_CRA, 8'h13);
        tick_n(4);
        rd(REG_TALO);
        rd(REG_TAHI);
        wr(REG_TODH, 8'h93);
        wr(REG_TODS, 8'h6a);
        wr(REG_TOD10, 8'h0c);
        rd(REG_TODH);
        rd(REG_TOD10);
        wr(REG_ICR, 8'h9f);
        it = '{FUNC_NONE, 4'hf, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0};
        send_beat(it);
        send_beat('{FUNC_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1});
        rd(REG_ICR);
        flag_drv = 1;
    endtask

    task automatic test_timers();
        repeat (12) begin
            wr(REG_TALO, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 6)));
            wr(REG_TAHI, $urandom_range(0, 7) == 0 ? 8'hff : 8'h00);
            wr(REG_TBLO, 8'($urandom_range(0, 4)));
            wr(REG_TBHI, 8'h00);
            wr(REG_ICR, 8'h83);
            wr(REG_CRA, 8'($urandom) & 8'hbf);
            wr(REG_CRB, 8'($urandom) & 8'h7f);
            repeat (25) begin
                if ($urandom_range(0, 5) == 0) begin
                    rd($urandom_range(0, 1) ? REG_ICR : 4'($urandom_range(4, 7)));
                end else if ($urandom_range(0, 12) == 0) begin
                    wr($urandom_range(0, 1) ? REG_CRA : REG_CRB, 8'($urandom) & 8'h7f);
                end else begin
                    tick_n(1);
                end
            end
            rd(REG_PRB);
        end
    endtask

    task automatic test_serial();
        wr(REG_TALO, 8'h02);
        wr(REG_TAHI, 8'h00);
        wr(REG_ICR, 8'h88);
        wr(REG_CRA, 8'h51);
        wr(REG_SDR, 8'($urandom));
        wr(REG_SDR, 8'($urandom));
        repeat (70) tick_n(1);
        rd(REG_ICR);
        wr(REG_CRA, 8'h00);
        repeat (40) tick_n(1);
        rd(REG_SDR);
        rd(REG_ICR);
    endtask

    task automatic test_tod();
        set_divider(CFG_DIV50, 24'd3);
        set_divider(CFG_DIV60, 24'd2);
        wr(REG_CRB, 8'h80);
        wr(REG_TODH, 8'h12);
        wr(REG_TODM, 8'h00);
        wr(REG_TODS, 8'h00);
        wr(REG_TOD10, 8'h03);
        wr(REG_CRB, 8'h00);
        wr(REG_ICR, 8'h84);
        wr(REG_TODH, 8'h91);
        wr(REG_TODM, 8'h59);
        wr(REG_TODS, 8'h59);
        wr(REG_TOD10, 8'h08);
        repeat (60) begin
            if ($urandom_range(0, 4) == 0) rd(4'($urandom_range(8, 11)));
            else tick_n(1);
        end
        wr(REG_CRA, 8'h80);
        tick_n(20);
        rd(REG_ICR);
        wr(REG_CRA, 8'h00);
        set_divider(CFG_DIV60, 24'd150);
        tick_n(120);
        set_divider(CFG_DIV60, 24'd1);
        repeat (40) begin
            if ($urandom_range(0, 3) == 0) rd(4'($urandom_range(8, 11)));
            else tick_n(1);
        end
        set_divider(CFG_DIV60, 24'd0);
        tick_n(10);
        rd(REG_TOD10);
        set_divider(CFG_DIV50, 24'hffffff);
        wr(REG_CRA, 8'h80);
        tick_n(10);
        set_divider(CFG_DIV60, 24'd5);
        set_divider(CFG_DIV50, 24'd4);
        wr(REG_CRA, 8'h00);
    endtask

    task automatic test_random();
        int r;
        bit [3:0] a;
        while (n_sent < 1550) begin
            if (n_sent % 120 == 0) no_idle = $urandom_range(0, 3) == 0;
            r = $urandom_range(0, 99);
            a = 4'($urandom);
            if (r < 55) tick_n(1);
            else if (r < 75) rd(a);
            else if (r < 97) begin
                if (a == REG_TAHI || a == REG_TBHI) wr(a, 8'($urandom_range(0, 3)));
                else wr(a, 8'($urandom));
            end else send_beat(make_beat(FUNC_NONE, a, 8'($urandom)));
        end
        no_idle = 0;
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_b;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_beats.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result beat %h", $realtime, out_if.payload);
            end else begin
                exp_b = expected_beats.pop_front();
                n_checked++;
                if (out_if.payload !== exp_b) begin
                    n_errors++;
                    $display("%0t: mismatch exp rd=%h irq=%b pc=%b sp=%b pa=%h pb=%h",
                             $realtime, exp_b.read_data, exp_b.irq_line, exp_b.pc_line,
                             exp_b.sp_out, exp_b.port_a_out, exp_b.port_b_out);
                    $display("%0t:          got rd=%h irq=%b pc=%b sp=%b pa=%h pb=%h",
                             $realtime, out_if.payload.read_data, out_if.payload.irq_line,
                             out_if.payload.pc_line, out_if.payload.sp_out,
                             out_if.payload.port_a_out, out_if.payload.port_b_out);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_if.ready <= 1'b0;
            out_stall--;
        end else begin
            out_if.ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("%0t: run did not finish in time", $realtime);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        out_stall = 0;
        flag_drv = 1;
        no_idle = 0;
        adapter_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_timers();
        test_serial();
        test_tod();
        test_random();
        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats (%0d ticks, %0d reads, %0d writes), checked %0d results.",
                 n_sent, n_ticks, n_reads, n_writes, n_checked);
        $display("Covered timers, serial shifter, time of day with alarm and divider changes.");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/cia_pkg.sv
sv/cia_stream_if.sv
sv/cia_tod_adv.sv
sv/interface_adapter_timers_tod_serial.sv
dv/tb_top.sv
